// ===== design/cgcd_pkg.sv =====
// ----------------------------------------------------------------------------
// cgcd_pkg - shared types and constants for the compressor gain computer
// Field widths, configuration register map, microcode word layout and the
// microcode program itself.
// ----------------------------------------------------------------------------
package cgcd_pkg;

	// field widths
	localparam int LEVEL_W   = 24;
	localparam int RED_W     = 25;
	localparam int SLOPE_W   = 16;
	localparam int KW_W      = 22;
	localparam int KG_W      = 24;
	localparam int COEF_W    = 20;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;
	localparam int OUT_W     = 56;

	// datapath widths
	localparam int MUL_A_W = 30;
	localparam int MUL_B_W = 25;
	localparam int PROD_W  = 55;
	localparam int SQ_W    = 29;
	localparam int F2_W    = 23;
	localparam int POLE_W  = 17;
	localparam int STEP_W  = 4;

	localparam logic [POLE_W-1:0] POLE_ONE = 17'h10000;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATIO_SLOPE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KNEE_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KNEE_GAIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_COMPENSATION = 3'd7;

	// register reset values
	localparam logic [LEVEL_W-1:0] THRESHOLD_RST    = 24'hF40000; // -12 dB
	localparam logic [SLOPE_W-1:0] RATIO_SLOPE_RST  = 16'h8000;
	localparam logic [KW_W-1:0]    KNEE_WIDTH_RST   = 22'h0;
	localparam logic [KG_W-1:0]    KNEE_GAIN_RST    = 24'h0;
	localparam logic [COEF_W-1:0]  ATTACK_RST       = 20'd65128;
	localparam logic [COEF_W-1:0]  RELEASE_RST      = 20'd65495;
	localparam logic               MODE_RST         = 1'b1;
	localparam logic [LEVEL_W-1:0] COMPENSATION_RST = 24'h060000; // 6 dB

	typedef struct packed {
		logic signed [LEVEL_W-1:0] threshold;
		logic [SLOPE_W-1:0]        ratio_slope;
		logic [KW_W-1:0]           knee_width;
		logic [KG_W-1:0]           knee_gain;
		logic [COEF_W-1:0]         attack;
		logic [COEF_W-1:0]         release_c;
		logic                      smooth_mode;
		logic signed [LEVEL_W-1:0] compensation;
	} cfg_t;

	// status flags the sequencer branches on
	typedef struct packed {
		logic in_valid;
		logic hard;
		logic out_busy;
	} stat_t;

	typedef enum logic [1:0] {
		A_D    = 2'd0,
		A_F2   = 2'd1,
		A_SQ   = 2'd2,
		A_DIFF = 2'd3
	} a_sel_t;

	typedef enum logic [1:0] {
		B_RATIO = 2'd0,
		B_F2    = 2'd1,
		B_KGAIN = 2'd2,
		B_COEF  = 2'd3
	} b_sel_t;

	typedef enum logic [1:0] {
		TGT_HOLD = 2'd0,
		TGT_LIN  = 2'd1,
		TGT_KNEE = 2'd2
	} tgt_sel_t;

	typedef enum logic [1:0] {
		C_NEVER    = 2'd0,
		C_NO_IN    = 2'd1,
		C_HARD     = 2'd2,
		C_OUT_BUSY = 2'd3
	} cond_t;

	typedef struct packed {
		logic              accept;
		logic              ld_f2;
		logic              ld_sq;
		logic              ld_prod;
		a_sel_t            a_sel;
		b_sel_t            b_sel;
		tgt_sel_t          tgt_sel;
		logic              ld_state;
		logic              ld_out;
		cond_t             cond;
		logic [STEP_W-1:0] jmp;
		logic [STEP_W-1:0] nxt;
	} uword_t;

	// program addresses
	localparam logic [STEP_W-1:0] STEP_FETCH    = 4'd0;
	localparam logic [STEP_W-1:0] STEP_LIN_MUL  = 4'd1;
	localparam logic [STEP_W-1:0] STEP_LIN_TGT  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_SQ_RND   = 4'd3;
	localparam logic [STEP_W-1:0] STEP_KNEE_MUL = 4'd4;
	localparam logic [STEP_W-1:0] STEP_KNEE_TGT = 4'd5;
	localparam logic [STEP_W-1:0] STEP_POLE_MUL = 4'd6;
	localparam logic [STEP_W-1:0] STEP_UPDATE   = 4'd7;
	localparam logic [STEP_W-1:0] STEP_EMIT     = 4'd8;

	// microcode store: next step is jmp when the condition holds, else nxt
	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		w = '0;
		w.a_sel   = A_D;
		w.b_sel   = B_RATIO;
		w.tgt_sel = TGT_HOLD;
		w.cond    = C_NEVER;
		w.jmp     = STEP_FETCH;
		w.nxt     = STEP_FETCH;
		unique case (step)
			STEP_FETCH: begin
				w.accept = 1'b1;
				w.cond   = C_NO_IN;
				w.jmp    = STEP_FETCH;
				w.nxt    = STEP_LIN_MUL;
			end
			STEP_LIN_MUL: begin
				w.ld_prod = 1'b1;
				w.a_sel   = A_D;
				w.b_sel   = B_RATIO;
				w.ld_f2   = 1'b1;
				w.nxt     = STEP_LIN_TGT;
			end
			STEP_LIN_TGT: begin
				w.tgt_sel = TGT_LIN;
				w.ld_prod = 1'b1;
				w.a_sel   = A_F2;
				w.b_sel   = B_F2;
				w.cond    = C_HARD;
				w.jmp     = STEP_POLE_MUL;
				w.nxt     = STEP_SQ_RND;
			end
			STEP_SQ_RND: begin
				w.ld_sq = 1'b1;
				w.nxt   = STEP_KNEE_MUL;
			end
			STEP_KNEE_MUL: begin
				w.ld_prod = 1'b1;
				w.a_sel   = A_SQ;
				w.b_sel   = B_KGAIN;
				w.nxt     = STEP_KNEE_TGT;
			end
			STEP_KNEE_TGT: begin
				w.tgt_sel = TGT_KNEE;
				w.nxt     = STEP_POLE_MUL;
			end
			STEP_POLE_MUL: begin
				w.ld_prod = 1'b1;
				w.a_sel   = A_DIFF;
				w.b_sel   = B_COEF;
				w.nxt     = STEP_UPDATE;
			end
			STEP_UPDATE: begin
				w.ld_state = 1'b1;
				w.nxt      = STEP_EMIT;
			end
			STEP_EMIT: begin
				w.ld_out = 1'b1;
				w.cond   = C_OUT_BUSY;
				w.jmp    = STEP_EMIT;
				w.nxt    = STEP_FETCH;
			end
			default: begin
				w.nxt = STEP_FETCH;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== design/cgcd_seq.sv =====
// ----------------------------------------------------------------------------
// cgcd_seq - microcode sequencer
// Step counter, control store lookup and conditional branch selection.
// ----------------------------------------------------------------------------
module cgcd_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  cgcd_pkg::stat_t  stat,
	output cgcd_pkg::uword_t uw
);
	import cgcd_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic              taken;

	assign uw = ucode(step_q);

	always_comb begin
		unique case (uw.cond)
			C_NEVER:    taken = 1'b0;
			C_NO_IN:    taken = !stat.in_valid;
			C_HARD:     taken = stat.hard;
			C_OUT_BUSY: taken = stat.out_busy;
			default:    taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_FETCH;
		end else begin
			step_q <= taken ? uw.jmp : uw.nxt;
		end
	end

endmodule

// ===== design/cgcd_dp.sv =====
// ----------------------------------------------------------------------------
// cgcd_dp - datapath of the gain computer and level detector
// One shared multiplier, operand muxes, rounding and saturation, reduction
// state and the output register.
// ----------------------------------------------------------------------------
module cgcd_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cgcd_pkg::uword_t                      uw,
	input  cgcd_pkg::cfg_t                        cfg,
	input  logic                                  s_tvalid,
	input  logic signed [cgcd_pkg::LEVEL_W-1:0]   level,
	input  logic                                  m_tready,
	output cgcd_pkg::stat_t                       stat,
	output logic                                  m_tvalid,
	output logic signed [cgcd_pkg::RED_W-1:0]     gain_out,
	output logic signed [cgcd_pkg::RED_W-1:0]     comp_out
);
	import cgcd_pkg::*;

	localparam logic signed [PROD_W-1:0] RND16 = PROD_W'(32768);
	localparam logic signed [PROD_W-1:0] RND18 = PROD_W'(131072);
	localparam logic signed [PROD_W-1:0] TGT_MAX = PROD_W'(16777215);

	function automatic logic signed [RED_W-1:0] sat25(input logic signed [MUL_A_W-1:0] v);
		logic signed [MUL_A_W-1:0] hi;
		logic signed [MUL_A_W-1:0] lo;
		hi = MUL_A_W'(16777215);
		lo = -MUL_A_W'(16777216);
		if (v > hi)
			return RED_W'(hi);
		else if (v < lo)
			return RED_W'(lo);
		else
			return v[RED_W-1:0];
	endfunction

	logic signed [RED_W-1:0]   d_q;
	logic signed [RED_W-1:0]   tgt_q;
	logic signed [RED_W-1:0]   state_q;
	logic signed [RED_W-1:0]   gain_q;
	logic signed [RED_W-1:0]   comp_q;
	logic [F2_W-1:0]           f2_q;
	logic [SQ_W-1:0]           sq_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic                      m_tvalid_q;

	logic signed [RED_W-1:0]   d_next;
	logic signed [KW_W+5-1:0]  d2;
	logic signed [KW_W+5-1:0]  kw_ext;
	logic signed [KW_W+5-1:0]  f2_full;
	logic                      in_knee;
	logic signed [RED_W:0]     diff;
	logic                      attack_sel;
	logic [COEF_W-1:0]         coef_raw;
	logic [POLE_W-1:0]         coef_sat;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  product;
	logic signed [PROD_W-1:0]  r16;
	logic signed [PROD_W-1:0]  r18;
	logic signed [RED_W-1:0]   tgt_calc;
	logic signed [RED_W-1:0]   tgt_next;
	logic signed [MUL_A_W-1:0] sm_sum;
	logic signed [RED_W-1:0]   smooth_next;
	logic signed [RED_W+1:0]   up_sum;
	logic signed [RED_W+1:0]   dn_sum;
	logic signed [RED_W+1:0]   tgt_ext;
	logic signed [RED_W-1:0]   lin_next;
	logic signed [RED_W-1:0]   state_next;
	logic signed [RED_W:0]     comp_diff;
	logic                      out_busy;
	logic                      out_load;

	// gain computer front end
	assign d_next  = {level[LEVEL_W-1], level} - {cfg.threshold[LEVEL_W-1], cfg.threshold};
	assign d2      = {d_q[RED_W-1], d_q, 1'b0};
	assign kw_ext  = {5'b0, cfg.knee_width};
	assign f2_full = d2 + kw_ext;
	assign in_knee = (cfg.knee_width != '0) && !(d2 < -kw_ext) && !(d2 > kw_ext);

	// detector branch choice
	assign diff       = {state_q[RED_W-1], state_q} - {tgt_q[RED_W-1], tgt_q};
	assign attack_sel = tgt_q > state_q;
	assign coef_raw   = attack_sel ? cfg.attack : cfg.release_c;
	assign coef_sat   = (coef_raw > COEF_W'(POLE_ONE)) ? POLE_ONE : coef_raw[POLE_W-1:0];

	always_comb begin
		unique case (uw.a_sel)
			A_D:     mul_a = MUL_A_W'(d_q);
			A_F2:    mul_a = MUL_A_W'({1'b0, f2_q});
			A_SQ:    mul_a = MUL_A_W'({1'b0, sq_q});
			A_DIFF:  mul_a = MUL_A_W'(diff);
			default: mul_a = '0;
		endcase
		unique case (uw.b_sel)
			B_RATIO: mul_b = MUL_B_W'({1'b0, cfg.ratio_slope});
			B_F2:    mul_b = MUL_B_W'({1'b0, f2_q});
			B_KGAIN: mul_b = MUL_B_W'({1'b0, cfg.knee_gain});
			B_COEF:  mul_b = MUL_B_W'({1'b0, coef_sat});
			default: mul_b = '0;
		endcase
	end

	assign product = mul_a * mul_b;

	// round half up, then clamp the target to 0 .. full scale
	assign r16 = (prod_q + RND16) >>> 16;
	assign r18 = prod_q + RND18;

	always_comb begin
		if (r16 > TGT_MAX)
			tgt_calc = RED_W'(TGT_MAX);
		else if (r16 < 0)
			tgt_calc = '0;
		else
			tgt_calc = r16[RED_W-1:0];
	end

	always_comb begin
		unique case (uw.tgt_sel)
			TGT_HOLD: tgt_next = tgt_q;
			TGT_LIN:  tgt_next = (d_q > 0) ? tgt_calc : '0;
			TGT_KNEE: tgt_next = tgt_calc;
			default:  tgt_next = tgt_q;
		endcase
	end

	// one-pole blend: target + round(c * (state - target))
	assign sm_sum      = MUL_A_W'(tgt_q) + r16[MUL_A_W-1:0];
	assign smooth_next = (coef_raw == '0) ? tgt_q : sat25(sm_sum);

	// fixed step toward the target, stop at the target
	assign tgt_ext = (RED_W+2)'(tgt_q);
	assign up_sum  = (RED_W+2)'(state_q) + (RED_W+2)'({1'b0, cfg.attack});
	assign dn_sum  = (RED_W+2)'(state_q) - (RED_W+2)'({1'b0, cfg.release_c});

	always_comb begin
		priority if (tgt_q == state_q)
			lin_next = state_q;
		else if (tgt_q > state_q) begin
			if (cfg.attack == '0 || up_sum > tgt_ext)
				lin_next = tgt_q;
			else
				lin_next = up_sum[RED_W-1:0];
		end else begin
			if (cfg.release_c == '0 || dn_sum < tgt_ext)
				lin_next = tgt_q;
			else
				lin_next = dn_sum[RED_W-1:0];
		end
	end

	assign state_next = cfg.smooth_mode ? smooth_next : lin_next;
	assign comp_diff  = {state_q[RED_W-1], state_q}
		- (RED_W+1)'(cfg.compensation);

	assign out_busy = m_tvalid_q && !m_tready;
	assign out_load = uw.ld_out && !out_busy;

	assign stat.in_valid = s_tvalid;
	assign stat.hard     = !in_knee;
	assign stat.out_busy = out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (uw.ld_state)
				state_q <= state_next;
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.accept && s_tvalid)
			d_q <= d_next;
		if (uw.ld_f2)
			f2_q <= f2_full[F2_W-1:0];
		if (uw.ld_sq)
			sq_q <= r18[SQ_W+18-1:18];
		if (uw.ld_prod)
			prod_q <= product;
		tgt_q <= tgt_next;
		if (out_load) begin
			gain_q <= state_q;
			comp_q <= sat25(MUL_A_W'(comp_diff));
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign gain_out = gain_q;
	assign comp_out = comp_q;

endmodule

// ===== design/compressor_gain_computer_detector_top.sv =====
// ----------------------------------------------------------------------------
// compressor_gain_computer_detector_top - compressor gain computer + detector
// Turns a dB level per sample into a smoothed gain reduction and a
// compensated reduction, under a small microcoded sequencer.
// ----------------------------------------------------------------------------
//
//  channel   signals                          carries
//  --------  -------------------------------  ------------------------------
//  s_*       s_tvalid s_tready s_tdata[23:0]  input_level, Q8.16 dB
//  m_*       m_tvalid m_tready m_tdata[55:0]  gain_reduction, compensated
//  cfg_*     cfg_we cfg_index cfg_wdata       register writes, no read-back
//
//  Outside the soft knee an item runs from the fetch step through the linear
//  multiply, linear target, pole multiply and update steps to the emit step
//  that loads its result; inside the knee, the knee path adds three steps to
//  round the square and take the knee-gain product on the single shared
//  multiplier. Only one item is in flight at a time.
//  The next input transfer is taken right after the result is loaded, while
//  that result still waits in the output register.
//  A stalled output (m_tready low with a result held) holds the sequencer at
//  its emit step until the transfer happens.
//  arst_n clears the sequencer, the reduction state and the output valid, and
//  loads every configuration register with its reset value.
//
module compressor_gain_computer_detector_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// s_tdata: [23:0] input_level
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [cgcd_pkg::LEVEL_W-1:0]      s_tdata,
	// m_tdata: [24:0] gain_reduction, [49:25] compensated_reduction, [55:50] zero
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [cgcd_pkg::OUT_W-1:0]        m_tdata,
	input  logic                              cfg_we,
	input  logic [cgcd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cgcd_pkg::CFG_W-1:0]        cfg_wdata
);
	import cgcd_pkg::*;

	cfg_t                    cfg_q;
	uword_t                  uw;
	stat_t                   stat;
	logic signed [RED_W-1:0] gain_out;
	logic signed [RED_W-1:0] comp_out;

	// register file: mask each write to the register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold    <= THRESHOLD_RST;
			cfg_q.ratio_slope  <= RATIO_SLOPE_RST;
			cfg_q.knee_width   <= KNEE_WIDTH_RST;
			cfg_q.knee_gain    <= KNEE_GAIN_RST;
			cfg_q.attack       <= ATTACK_RST;
			cfg_q.release_c    <= RELEASE_RST;
			cfg_q.smooth_mode  <= MODE_RST;
			cfg_q.compensation <= COMPENSATION_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THRESHOLD:    cfg_q.threshold    <= cfg_wdata[LEVEL_W-1:0];
				CFG_RATIO_SLOPE:  cfg_q.ratio_slope  <= cfg_wdata[SLOPE_W-1:0];
				CFG_KNEE_WIDTH:   cfg_q.knee_width   <= cfg_wdata[KW_W-1:0];
				CFG_KNEE_GAIN:    cfg_q.knee_gain    <= cfg_wdata[KG_W-1:0];
				CFG_ATTACK:       cfg_q.attack       <= cfg_wdata[COEF_W-1:0];
				CFG_RELEASE:      cfg_q.release_c    <= cfg_wdata[COEF_W-1:0];
				CFG_MODE:         cfg_q.smooth_mode  <= cfg_wdata[0];
				CFG_COMPENSATION: cfg_q.compensation <= cfg_wdata[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer: step counter walks the control store, branching on status
	cgcd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.uw     (uw)
	);

	// datapath: shared multiplier, reduction state, output register
	cgcd_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.uw       (uw),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.level    (s_tdata),
		.m_tready (m_tready),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.gain_out (gain_out),
		.comp_out (comp_out)
	);

	// ready only on the fetch step
	assign s_tready = uw.accept;
	assign m_tdata  = {{(OUT_W - 2*RED_W){1'b0}}, comp_out, gain_out};

endmodule

// ===== design/cgcd_checker.sv =====
// ----------------------------------------------------------------------------
// cgcd_checker - port level checks for the gain computer
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module cgcd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [cgcd_pkg::OUT_W-1:0]     m_tdata,
	input logic                           cfg_we
);
	import cgcd_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or dropped");

	// one item in flight: no input transfer right after another
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in a row");

	// a freshly loaded result frees the input side
	a_ready_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("input not ready after result load");

	// padding above the two result fields stays clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_W-1:2*RED_W] == '0)
		else $error("result padding not zero");

	// register writes land only while the block is idle
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> s_tready && !m_tvalid)
		else $error("register written with an item in flight");

endmodule

bind compressor_gain_computer_detector_top cgcd_checker u_chk (.*);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - compressor gain computer and detector check
// Feeds dB levels through the input stream and compares every output result
// with an in-bench predictor of the gain computer and detector or with a value typed in by hand.
// The run starts with a directed table, then walks randomized setups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import cgcd_pkg::*;

	localparam longint RED_MAX         = 16777215;
	localparam longint RED_MIN         = -16777216;
	localparam longint LEVEL_MAX       = 8388607;
	localparam longint LEVEL_MIN       = -8388608;
	localparam int     RAND_PHASES     = 12;
	localparam int     ITEMS_PER_PHASE = 158;

	// one output transfer: gain_reduction and compensated_reduction
	typedef struct packed {
		logic [RED_W-1:0] gr;
		logic [RED_W-1:0] comp;
	} reduction_pair_t;

	// a row of the directed table is a register write or one level
	typedef enum bit {ROW_WRITE, ROW_LEVEL} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]  val;
		logic [LEVEL_W-1:0] lvl;
		bit                known;
		reduction_pair_t   hand;
	} row_t;

	// every input driven to a known value from time zero
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [LEVEL_W-1:0]   s_tdata   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	// both sides stall at random unless this is set
	bit steady = 1'b0;
	int mismatches = 0;

	// results still owed by the block, oldest first
	reduction_pair_t expected_reductions[$];

	// predictor copy of the registers and of the reduction state
	longint cur_threshold    = -786432;
	longint cur_slope        = 32768;
	longint cur_knee_width   = 0;
	longint cur_knee_gain    = 0;
	longint cur_attack       = 65128;
	longint cur_release      = 65495;
	bit     cur_smooth       = 1'b1;
	longint cur_compensation = 393216;
	longint reduction        = 0;

	compressor_gain_computer_detector_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	// hard stop well beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("status: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// round to nearest, halves toward plus infinity
	function automatic longint round_sh(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clip25(longint v);
		if (v > RED_MAX)
			return RED_MAX;
		if (v < RED_MIN)
			return RED_MIN;
		return v;
	endfunction

	// static curve: hard knee when the width is zero, else quadratic knee
	function automatic longint gain_target(longint lvl);
		longint d, lin, t, f2, sq;
		d = lvl - cur_threshold;
		lin = (d > 0) ? round_sh(d * cur_slope, 16) : 0;
		if (cur_knee_width == 0) begin
			t = (d <= 0) ? 0 : lin;
		end else if (2 * d < -cur_knee_width) begin
			t = 0;
		end else if (2 * d > cur_knee_width) begin
			t = lin;
		end else begin
			// twice the knee factor keeps the half width exact
			f2 = 2 * d + cur_knee_width;
			sq = round_sh(f2 * f2, 18);
			t = round_sh(sq * cur_knee_gain, 16);
		end
		if (t < 0)
			t = 0;
		if (t > RED_MAX)
			t = RED_MAX;
		return t;
	endfunction

	// advance the detector by one level and return the pair it yields
	function automatic reduction_pair_t predict_reduction(logic [LEVEL_W-1:0] lv);
		longint tgt, c, s, cr;
		reduction_pair_t r;
		tgt = gain_target(longint'($signed(lv)));
		if (cur_smooth) begin
			c = (tgt > reduction) ? cur_attack : cur_release;
			if (c == 0) begin
				reduction = tgt;
			end else begin
				// a pole above one saturates and freezes the state
				if (c > 65536)
					c = 65536;
				reduction = clip25(round_sh(c * reduction + (65536 - c) * tgt, 16));
			end
		end else begin
			s = reduction;
			if (tgt > s) begin
				if (cur_attack == 0 || s + cur_attack > tgt)
					s = tgt;
				else
					s = s + cur_attack;
			end else if (tgt < s) begin
				if (cur_release == 0 || s - cur_release < tgt)
					s = tgt;
				else
					s = s - cur_release;
			end
			reduction = clip25(s);
		end
		cr = clip25(reduction - cur_compensation);
		r.gr = reduction[RED_W-1:0];
		r.comp = cr[RED_W-1:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------

	// Present one level, hold it until the transfer, then log what is owed.
	// Leave tvalid high on return so back-to-back levels need no toggle.
	task automatic send_level(logic [LEVEL_W-1:0] lv, bit known, reduction_pair_t hand);
		reduction_pair_t pr;
		cfg_we <= 1'b0;
		if (!steady) begin
			while ($urandom_range(99) < 8) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= lv;
		do @(posedge clk); while (!s_tready);
		// the predictor always advances; typed rows only replace what is owed
		pr = predict_reduction(lv);
		expected_reductions.push_back(known ? hand : pr);
	endtask

	// Drop tvalid, drain every owed result, then write one register.
	// The drain is watched on the falling edge so it never races the sink.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		s_tvalid <= 1'b0;
		while (expected_reductions.size() != 0)
			@(negedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		// mirror the write, masked to the register width
		case (idx)
			CFG_THRESHOLD:    cur_threshold    = longint'($signed(val));
			CFG_RATIO_SLOPE:  cur_slope        = longint'(val[SLOPE_W-1:0]);
			CFG_KNEE_WIDTH:   cur_knee_width   = longint'(val[KW_W-1:0]);
			CFG_KNEE_GAIN:    cur_knee_gain    = longint'(val[KG_W-1:0]);
			CFG_ATTACK:       cur_attack       = longint'(val[COEF_W-1:0]);
			CFG_RELEASE:      cur_release      = longint'(val[COEF_W-1:0]);
			CFG_MODE:         cur_smooth       = val[0];
			CFG_COMPENSATION: cur_compensation = longint'($signed(val));
			default: ;
		endcase
	endtask

	// pole for smooth mode, dB step for linear mode
	function automatic logic [COEF_W-1:0] pick_coef(bit smooth);
		int r;
		r = $urandom_range(9);
		if (smooth) begin
			case (r)
				0:       return '0;
				1:       return COEF_W'(65536);
				2:       return COEF_W'($urandom_range(1048575, 65537));
				3, 4:    return COEF_W'($urandom_range(65535, 1));
				default: return COEF_W'($urandom_range(65535, 60000));
			endcase
		end
		case (r)
			0:          return '0;
			1:          return '1;
			2, 3, 4, 5: return COEF_W'($urandom_range(65536, 1));
			default:    return COEF_W'($urandom_range(655360, 1));
		endcase
	endfunction

	// Choose a full register setup for one random phase and write it.
	// The second to last phase takes every minimum (smooth mode), the last every maximum (linear mode).
	task automatic configure_phase(int ph);
		logic [CFG_W-1:0] vals [8];
		logic [CFG_W-1:0] keep;
		logic [CFG_IDX_W-1:0] idx;
		longint kg;
		int w, first, k;
		bit smooth;
		if (ph == RAND_PHASES - 2) begin
			vals[CFG_THRESHOLD]    = 24'h800000;
			vals[CFG_RATIO_SLOPE]  = '0;
			vals[CFG_KNEE_WIDTH]   = '0;
			vals[CFG_KNEE_GAIN]    = '0;
			vals[CFG_ATTACK]       = '0;
			vals[CFG_RELEASE]      = '0;
			vals[CFG_MODE]         = CFG_W'(1);
			vals[CFG_COMPENSATION] = 24'h800000;
		end else if (ph == RAND_PHASES - 1) begin
			vals[CFG_THRESHOLD]    = 24'h7FFFFF;
			vals[CFG_RATIO_SLOPE]  = 24'h00FFFF;
			vals[CFG_KNEE_WIDTH]   = 24'h3FFFFF;
			vals[CFG_KNEE_GAIN]    = 24'hFFFFFF;
			vals[CFG_ATTACK]       = 24'h0FFFFF;
			vals[CFG_RELEASE]      = 24'h0FFFFF;
			vals[CFG_MODE]         = '0;
			vals[CFG_COMPENSATION] = 24'h7FFFFF;
		end else begin
			smooth = (ph < 2) ? ph[0] : bit'($urandom_range(1));
			case ($urandom_range(5))
				0:       vals[CFG_THRESHOLD] = CFG_W'($urandom);
				1:       vals[CFG_THRESHOLD] = 24'h800000;
				2:       vals[CFG_THRESHOLD] = 24'h7FFFFF;
				default: vals[CFG_THRESHOLD] =
					CFG_W'(longint'($urandom_range(5242880)) - 2621440);
			endcase
			case ($urandom_range(4))
				0:       vals[CFG_RATIO_SLOPE] = '0;
				1:       vals[CFG_RATIO_SLOPE] = CFG_W'(65535);
				default: vals[CFG_RATIO_SLOPE] = CFG_W'($urandom_range(65535));
			endcase
			case ($urandom_range(7))
				0, 1:    vals[CFG_KNEE_WIDTH] = '0;
				5, 6:    vals[CFG_KNEE_WIDTH] = CFG_W'($urandom_range(262144, 1));
				7:       vals[CFG_KNEE_WIDTH] = CFG_W'(22'h3FFFFF);
				default: vals[CFG_KNEE_WIDTH] = CFG_W'($urandom_range(3145728, 1));
			endcase
			// mostly the gain that matches slope and width, sometimes anything
			if (vals[CFG_KNEE_WIDTH] != 0 && $urandom_range(3) != 0) begin
				kg = longint'(vals[CFG_RATIO_SLOPE][SLOPE_W-1:0]) * 32768 /
					longint'(vals[CFG_KNEE_WIDTH][KW_W-1:0]);
				vals[CFG_KNEE_GAIN] = (kg > 16777215) ? 24'hFFFFFF : CFG_W'(kg);
			end else begin
				vals[CFG_KNEE_GAIN] = CFG_W'($urandom);
			end
			vals[CFG_ATTACK]  = CFG_W'(pick_coef(smooth));
			vals[CFG_RELEASE] = CFG_W'(pick_coef(smooth));
			vals[CFG_MODE]    = CFG_W'(smooth);
			case ($urandom_range(5))
				0:       vals[CFG_COMPENSATION] = CFG_W'($urandom);
				1:       vals[CFG_COMPENSATION] = 24'h800000;
				2:       vals[CFG_COMPENSATION] = 24'h7FFFFF;
				default: vals[CFG_COMPENSATION] =
					CFG_W'(longint'($urandom_range(3145728)) - 1572864);
			endcase
		end
		// write in a rotated order; junk above a narrow register must be ignored
		first = $urandom_range(7);
		for (k = 0; k < 8; k++) begin
			idx = CFG_IDX_W'(first + k);
			case (idx)
				CFG_RATIO_SLOPE:         w = SLOPE_W;
				CFG_KNEE_WIDTH:          w = KW_W;
				CFG_ATTACK, CFG_RELEASE: w = COEF_W;
				CFG_MODE:                w = 1;
				default:                 w = CFG_W;
			endcase
			keep = ~(24'hFFFFFF << w);
			if ($urandom_range(1))
				write_reg(idx, (vals[idx] & keep) | (CFG_W'($urandom) & ~keep));
			else
				write_reg(idx, vals[idx] & keep);
		end
	endtask

	// ------------------------------------------------------------------
	// result sink: check each transfer against the oldest owed pair
	// ------------------------------------------------------------------
	always @(posedge clk) begin : sink
		reduction_pair_t want, got;
		if (m_tvalid && m_tready) begin
			got.gr = m_tdata[RED_W-1:0];
			got.comp = m_tdata[2*RED_W-1:RED_W];
			if (expected_reductions.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing owed, expected none, actual %0d / %0d",
					$time, $signed(got.gr), $signed(got.comp));
			end else begin
				want = expected_reductions.pop_front();
				if (got.gr !== want.gr) begin
					mismatches++;
					$display("%0t: gain_reduction expected %0d actual %0d",
						$time, $signed(want.gr), $signed(got.gr));
				end
				if (got.comp !== want.comp) begin
					mismatches++;
					$display("%0t: compensated_reduction expected %0d actual %0d",
						$time, $signed(want.comp), $signed(got.comp));
				end
			end
		end
		// stall at random about 8 percent of the time, never in steady stretches
		m_tready <= steady || ($urandom_range(99) >= 8);
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	function automatic row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		row_t r;
		r.kind = ROW_WRITE;
		r.idx = idx;
		r.val = val;
		r.lvl = '0;
		r.known = 1'b0;
		r.hand = '0;
		return r;
	endfunction

	function automatic row_t level_row(logic [LEVEL_W-1:0] lvl);
		row_t r;
		r.kind = ROW_LEVEL;
		r.idx = '0;
		r.val = '0;
		r.lvl = lvl;
		r.known = 1'b0;
		r.hand = '0;
		return r;
	endfunction

	// a level whose result is plain from the setup, typed in by hand
	function automatic row_t known_row(logic [LEVEL_W-1:0] lvl, logic [RED_W-1:0] gr,
			logic [RED_W-1:0] comp);
		row_t r;
		r = level_row(lvl);
		r.known = 1'b1;
		r.hand.gr = gr;
		r.hand.comp = comp;
		return r;
	endfunction

	initial begin : stimulus
		row_t rows[$];
		reduction_pair_t none;
		longint span, lv;
		int hold, ph, n;
		none = '0;
		lv = 0;
		hold = 0;

		// single reset at the start, released on a clock edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setup: smooth detector, hard knee at -12 dB, 6 dB makeup
		rows.push_back(known_row(-8388608, 0, -393216));
		rows.push_back(known_row(-786432, 0, -393216));   // on the threshold
		rows.push_back(level_row(-786431));               // half step rounds up
		rows.push_back(level_row(8388607));
		// zero coefficients: state jumps to the target
		rows.push_back(reg_row(CFG_ATTACK, 0));
		rows.push_back(reg_row(CFG_RELEASE, 0));
		rows.push_back(known_row(8388607, 4587520, 4194304));
		rows.push_back(known_row(-8388608, 0, -393216));
		// widest level span and steepest slope; slope write carries junk bits
		rows.push_back(reg_row(CFG_THRESHOLD, 24'h800000));
		rows.push_back(reg_row(CFG_RATIO_SLOPE, 24'hFFFFFF));
		rows.push_back(reg_row(CFG_COMPENSATION, 24'h7FFFFF));
		rows.push_back(level_row(8388607));
		rows.push_back(known_row(-8388608, 0, -8388607));
		rows.push_back(reg_row(CFG_COMPENSATION, 24'h800000));
		rows.push_back(level_row(8388607));               // compensated saturates
		// 6 dB soft knee around 0 dB, 2:1
		rows.push_back(reg_row(CFG_THRESHOLD, 0));
		rows.push_back(reg_row(CFG_RATIO_SLOPE, 32768));
		rows.push_back(reg_row(CFG_KNEE_WIDTH, 393216));
		rows.push_back(reg_row(CFG_KNEE_GAIN, 2731));
		rows.push_back(reg_row(CFG_COMPENSATION, 0));
		rows.push_back(known_row(-196609, 0, 0));         // just below the knee
		rows.push_back(known_row(-196608, 0, 0));         // knee start
		rows.push_back(level_row(0));
		rows.push_back(level_row(196608));                // knee end
		rows.push_back(level_row(196609));                // above the knee
		// poles above one hold the state
		rows.push_back(reg_row(CFG_ATTACK, 24'h0FFFFF));
		rows.push_back(reg_row(CFG_RELEASE, 655360));
		rows.push_back(level_row(8388607));
		// linear detector, hard knee: 1 dB attack step, 2 dB release step
		rows.push_back(reg_row(CFG_MODE, 0));
		rows.push_back(reg_row(CFG_ATTACK, 65536));
		rows.push_back(reg_row(CFG_RELEASE, 131072));
		rows.push_back(reg_row(CFG_KNEE_WIDTH, 0));
		rows.push_back(level_row(1310720));
		rows.push_back(level_row(1310720));
		rows.push_back(level_row(1310720));
		rows.push_back(level_row(-8388608));
		rows.push_back(reg_row(CFG_ATTACK, 0));
		rows.push_back(level_row(8388607));
		rows.push_back(level_row(8388607));               // target equals state

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_WRITE)
				write_reg(rows[i].idx, rows[i].val);
			else
				send_level(rows[i].lvl, rows[i].known, rows[i].hand);
		end

		// random phases: mostly levels around the threshold and knee, held in
		// runs so the detector settles, plus full-range noise and edges
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			steady = 1'b0;
			configure_phase(ph);
			steady = (ph == 3 || ph == 4);
			hold = 0;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (hold > 0) begin
					hold--;
				end else begin
					span = cur_knee_width + 1048576;
					case ($urandom_range(19))
						14, 15, 16: lv = longint'($signed(LEVEL_W'($urandom)));
						17, 18: begin
							case ($urandom_range(6))
								0: lv = cur_threshold;
								1: lv = cur_threshold + 1;
								2: lv = cur_threshold - 1;
								3: lv = cur_threshold + cur_knee_width / 2;
								4: lv = cur_threshold - cur_knee_width / 2;
								5: lv = cur_threshold + cur_knee_width / 2 + 1;
								default: lv = cur_threshold - cur_knee_width / 2 - 1;
							endcase
						end
						19: lv = $urandom_range(1) ? LEVEL_MAX : LEVEL_MIN;
						default: lv = cur_threshold +
							longint'($urandom_range(32'(2 * span))) - span;
					endcase
					if (lv > LEVEL_MAX)
						lv = LEVEL_MAX;
					if (lv < LEVEL_MIN)
						lv = LEVEL_MIN;
					hold = ($urandom_range(3) == 0) ? $urandom_range(10, 1) : 0;
				end
				send_level(LEVEL_W'(lv), 1'b0, none);
			end
		end

		// drain, then allow the block's own latency before the verdict
		s_tvalid <= 1'b0;
		cfg_we <= 1'b0;
		steady = 1'b0;
		while (expected_reductions.size() != 0)
			@(negedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
